// ----- rtl/gckm_pkg.sv -----
// ---------------------------------------------------------------------------
// gckm_pkg: shared types and constants of the checked gain mixer
// Field widths, status and register codes, and the packet that moves
// along the row of mixer cells.
// ---------------------------------------------------------------------------
package gckm_pkg;

   localparam int SRC_COUNT       = 6;   // source fields on the request channel
   localparam int SAMPLE_W        = 18;
   localparam int GAIN_W          = 18;
   localparam int PROD_W          = SAMPLE_W + GAIN_W;
   // Running sum width: covers +/-ONE up to 2^30 and a scaled term at the
   // smallest gain fraction width.
   localparam int ACC_W           = 32;
   localparam int STATUS_W        = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 18;
   localparam int COUNT_W         = 3;

   localparam int MAX_SOURCES_DEF      = 6;
   localparam int SAMPLE_FRAC_BITS_DEF = 16;
   localparam int GAIN_FRAC_BITS_DEF   = 14;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INPUT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MIX   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MASTER = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_3 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_4 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_5 = 3'd7;

   // Reset values
   localparam logic [COUNT_W-1:0]       ACTIVE_RESET = 3'd1;
   localparam logic [COUNT_W-1:0]       MASTER_RESET = 3'd0;
   localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 18'sd16384;

   typedef struct packed {
      logic [SRC_COUNT-1:0][SAMPLE_W-1:0] samples;
      logic signed [ACC_W-1:0]            sum;
      logic [STATUS_W-1:0]                status;
      logic                               frame_end;
   } gckm_pkt_type;

endpackage

// ----- rtl/gckm_req_if.sv -----
// ---------------------------------------------------------------------------
// gckm_req_if: request channel of the checked gain mixer
// One sample position from every source plus the frame end marker.
// ---------------------------------------------------------------------------
interface gckm_req_if
   import gckm_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] src_sample_0;
   logic signed [SAMPLE_W-1:0] src_sample_1;
   logic signed [SAMPLE_W-1:0] src_sample_2;
   logic signed [SAMPLE_W-1:0] src_sample_3;
   logic signed [SAMPLE_W-1:0] src_sample_4;
   logic signed [SAMPLE_W-1:0] src_sample_5;
   logic                       frame_end;

   modport source (
      output valid, src_sample_0, src_sample_1, src_sample_2, src_sample_3,
             src_sample_4, src_sample_5, frame_end,
      input  ready
   );

   modport sink (
      input  valid, src_sample_0, src_sample_1, src_sample_2, src_sample_3,
             src_sample_4, src_sample_5, frame_end,
      output ready
   );
endinterface

// ----- rtl/gckm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// gckm_rsp_if: result channel of the checked gain mixer
// Mixed sample with per-sample and per-frame status.
// ---------------------------------------------------------------------------
interface gckm_rsp_if
   import gckm_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mixed_sample;
   logic [STATUS_W-1:0]        sample_status;
   logic [STATUS_W-1:0]        frame_status;
   logic                       frame_last;

   modport source (
      output valid, mixed_sample, sample_status, frame_status, frame_last,
      input  ready
   );

   modport sink (
      input  valid, mixed_sample, sample_status, frame_status, frame_last,
      output ready
   );
endinterface

// ----- rtl/gckm_cell.sv -----
// ---------------------------------------------------------------------------
// gckm_cell: one mixer cell
// Checks its tap sample, scales it by its gain, adds it to the running sum
// and checks the sum. Two register stages: product, then sum.
// ---------------------------------------------------------------------------
module gckm_cell
   import gckm_pkg::*;
#(
   parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF,
   parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tap_en,
   input  logic signed [SAMPLE_W-1:0] tap_sample,
   input  logic signed [GAIN_W-1:0]   tap_gain,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  gckm_pkt_type               up_pkt,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output gckm_pkt_type               dn_pkt
);

   localparam logic signed [ACC_W-1:0]  ONE_VAL    = ACC_W'(64'sd1 <<< SAMPLE_FRAC_BITS);
   localparam logic signed [ACC_W-1:0]  NEG_ONE    = -ONE_VAL;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (GAIN_FRAC_BITS - 1));

   // stage A: check and multiply
   logic                       a_valid_ff;
   gckm_pkt_type               a_pkt_ff, a_pkt_in;
   logic signed [PROD_W-1:0]   a_prod_ff, a_prod_in;
   logic                       a_add_ff, a_add_in;
   logic                       a_adv;
   logic signed [ACC_W-1:0]    smp_ext;
   logic                       smp_ok;

   // stage B: round, add, check
   logic                       b_valid_ff;
   gckm_pkt_type               b_pkt_ff, b_pkt_in;
   logic                       b_adv;
   logic signed [ACC_W-1:0]    scaled;
   logic signed [ACC_W-1:0]    sum_new;

   assign b_adv    = !b_valid_ff || dn_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign up_ready = a_adv;

   assign smp_ext = ACC_W'(tap_sample);
   assign smp_ok  = (smp_ext >= NEG_ONE) && (smp_ext <= ONE_VAL);

   always_comb begin
      a_pkt_in  = up_pkt;
      a_add_in  = 1'b0;
      a_prod_in = tap_sample * tap_gain;
      if (tap_en && (up_pkt.status == ST_OK)) begin
         if (smp_ok) begin
            a_add_in = 1'b1;
         end else begin
            a_pkt_in.status = ST_INPUT;
         end
      end
   end

   assign scaled  = ACC_W'((a_prod_ff + ROUND_HALF) >>> GAIN_FRAC_BITS);
   assign sum_new = a_pkt_ff.sum + scaled;

   always_comb begin
      b_pkt_in = a_pkt_ff;
      if (a_add_ff) begin
         if ((sum_new >= NEG_ONE) && (sum_new <= ONE_VAL)) begin
            b_pkt_in.sum = sum_new;
         end else begin
            b_pkt_in.status = ST_MIX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= up_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && up_valid) begin
         a_pkt_ff  <= a_pkt_in;
         a_prod_ff <= a_prod_in;
         a_add_ff  <= a_add_in;
      end
      if (b_adv && a_valid_ff) begin
         b_pkt_ff <= b_pkt_in;
      end
   end

   assign dn_valid = b_valid_ff;
   assign dn_pkt   = b_pkt_ff;

endmodule

// ----- rtl/checked_gain_mixer.sv -----
// ---------------------------------------------------------------------------
// checked_gain_mixer: weighted mix of up to six sources with range checks
// A row of mixer cells: the master cell first, then one cell per source in
// index order, then the frame status stage and the result register.
// ---------------------------------------------------------------------------
//
//  channel  | dir | transfer when         | contents
//  ---------+-----+-----------------------+---------------------------------
//  req_ch   | in  | valid && ready        | six Q1.16 samples, frame_end
//  rsp_ch   | out | valid && ready        | mix, sample/frame status, last
//  csr_*    | in  | csr_we                | index 0..7, 18-bit data
//
//  Throughput: one sample position per cycle, sustained while rsp_ch.ready is high.
//  Path from request to result: each cell holds a product register and a
//  sum register, and the result register follows the last cell.
//  Reset: synchronous; empties the cell row, clears the frame error and
//  loads the register defaults. No clearing pass.
//  Stalls: every stage moves when the one after it is empty or moving, so
//  bubbles close up and requests keep flowing while a result waits, until
//  every stage of the row holds a transfer.
//
module checked_gain_mixer
   import gckm_pkg::*;
#(
   parameter int MAX_SOURCES      = MAX_SOURCES_DEF,
   parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF,
   parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   gckm_req_if.sink                req_ch,
   gckm_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CELLS = MAX_SOURCES + 1;

   // ---------------- configuration registers ----------------
   logic [COUNT_W-1:0]       active_ff;
   logic [COUNT_W-1:0]       master_ff;
   logic signed [GAIN_W-1:0] gain_ff [SRC_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         master_ff <= MASTER_RESET;
         for (int i = 0; i < SRC_COUNT; i++) begin
            gain_ff[i] <= GAIN_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ACTIVE: active_ff <= csr_data[COUNT_W-1:0];
            REG_MASTER: master_ff <= csr_data[COUNT_W-1:0];
            REG_GAIN_0: gain_ff[0] <= $signed(csr_data[GAIN_W-1:0]);
            REG_GAIN_1: gain_ff[1] <= $signed(csr_data[GAIN_W-1:0]);
            REG_GAIN_2: gain_ff[2] <= $signed(csr_data[GAIN_W-1:0]);
            REG_GAIN_3: gain_ff[3] <= $signed(csr_data[GAIN_W-1:0]);
            REG_GAIN_4: gain_ff[4] <= $signed(csr_data[GAIN_W-1:0]);
            REG_GAIN_5: gain_ff[5] <= $signed(csr_data[GAIN_W-1:0]);
            default: ;
         endcase
      end
   end

   // Effective source count (0 acts as 1, clamp to MAX_SOURCES) and master
   // (falls back to source 0 when not below the count).
   logic [COUNT_W-1:0] n_eff;
   logic [COUNT_W-1:0] m_eff;

   always_comb begin
      if (active_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (active_ff > COUNT_W'(MAX_SOURCES)) begin
         n_eff = COUNT_W'(MAX_SOURCES);
      end else begin
         n_eff = active_ff;
      end
      m_eff = (master_ff >= n_eff) ? '0 : master_ff;
   end

   // ---------------- cell row ----------------
   gckm_pkt_type chain_pkt   [CELLS+1];
   logic         chain_valid [CELLS+1];
   logic         chain_ready [CELLS+1];
   logic signed [SAMPLE_W-1:0] master_sample;

   always_comb begin
      chain_pkt[0]            = '0;
      chain_pkt[0].samples[0] = req_ch.src_sample_0;
      chain_pkt[0].samples[1] = req_ch.src_sample_1;
      chain_pkt[0].samples[2] = req_ch.src_sample_2;
      chain_pkt[0].samples[3] = req_ch.src_sample_3;
      chain_pkt[0].samples[4] = req_ch.src_sample_4;
      chain_pkt[0].samples[5] = req_ch.src_sample_5;
      chain_pkt[0].sum        = '0;
      chain_pkt[0].status     = ST_OK;
      chain_pkt[0].frame_end  = req_ch.frame_end;
   end

   assign chain_valid[0] = req_ch.valid;
   assign req_ch.ready   = chain_ready[0];
   assign master_sample  = $signed(chain_pkt[0].samples[m_eff]);

   // master cell: the running sum starts at zero, so it is an ordinary cell
   gckm_cell #(
      .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
      .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
   ) u_master (
      .clock      (clock),
      .reset      (reset),
      .tap_en     (1'b1),
      .tap_sample (master_sample),
      .tap_gain   (gain_ff[m_eff]),
      .up_valid   (chain_valid[0]),
      .up_ready   (chain_ready[0]),
      .up_pkt     (chain_pkt[0]),
      .dn_valid   (chain_valid[1]),
      .dn_ready   (chain_ready[1]),
      .dn_pkt     (chain_pkt[1])
   );

   // one cell per source; inactive ones and the master pass the packet on
   for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_src
      logic src_en;
      assign src_en = (COUNT_W'(i) < n_eff) && (COUNT_W'(i) != m_eff);

      gckm_cell #(
         .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
         .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tap_en     (src_en),
         .tap_sample ($signed(chain_pkt[i+1].samples[i])),
         .tap_gain   (gain_ff[i]),
         .up_valid   (chain_valid[i+1]),
         .up_ready   (chain_ready[i+1]),
         .up_pkt     (chain_pkt[i+1]),
         .dn_valid   (chain_valid[i+2]),
         .dn_ready   (chain_ready[i+2]),
         .dn_pkt     (chain_pkt[i+2])
      );
   end

   // ---------------- frame status and result register ----------------
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] mixed_ff;
   logic [STATUS_W-1:0]        sstat_ff;
   logic [STATUS_W-1:0]        fstat_ff;
   logic                       last_ff;
   logic [STATUS_W-1:0]        frame_err_ff, frame_err_in;
   logic [STATUS_W-1:0]        fstat_cur;
   logic                       out_adv;
   logic                       out_load;
   gckm_pkt_type               tail_pkt;

   assign tail_pkt           = chain_pkt[CELLS];
   assign out_adv            = !rsp_valid_ff || rsp_ch.ready;
   assign out_load           = out_adv && chain_valid[CELLS];
   assign chain_ready[CELLS] = out_adv;

   // first error of the frame wins; cleared after the frame's last result
   assign fstat_cur    = (frame_err_ff == ST_OK) ? tail_pkt.status : frame_err_ff;
   assign frame_err_in = tail_pkt.frame_end ? ST_OK : fstat_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         frame_err_ff <= ST_OK;
      end else begin
         if (out_adv) begin
            rsp_valid_ff <= chain_valid[CELLS];
         end
         if (out_load) begin
            frame_err_ff <= frame_err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mixed_ff <= (tail_pkt.status == ST_OK) ? tail_pkt.sum[SAMPLE_W-1:0] : '0;
         sstat_ff <= tail_pkt.status;
         fstat_ff <= fstat_cur;
         last_ff  <= tail_pkt.frame_end;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mixed_sample  = mixed_ff;
   assign rsp_ch.sample_status = sstat_ff;
   assign rsp_ch.frame_status  = fstat_ff;
   assign rsp_ch.frame_last    = last_ff;

   // ---------------- assertions ----------------
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (sstat_ff != ST_OK)) |-> (mixed_ff == '0))
      else $error("failed sample not forced to zero");

   a_fail_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (sstat_ff != ST_OK)) |-> (fstat_ff != ST_OK))
      else $error("sample error missing from frame status");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (out_load && tail_pkt.frame_end) |=> (frame_err_ff == ST_OK))
      else $error("frame error not cleared after frame end");

endmodule
